>>> design/multi_timer_table_macros.svh
// assertion macros for the multi timer table checker
// no dependencies; expects i_clk and i_rst_n in the including scope
`ifndef MULTI_TIMER_TABLE_MACROS_SVH
`define MULTI_TIMER_TABLE_MACROS_SVH

// antecedent now, consequent in the next cycle, off while in reset
`define MTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent in the cycle after a reset cycle
`define MTT_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

>>> design/mtt_pkg.sv
// shared types and constants of the multi timer table
// used by the controller, datapath, divider, top level and checker
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

    localparam int ID_W       = 16;
    localparam int IV_W       = 24;
    localparam int FUNC_W     = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK = 2'd0,
        FN_SET  = 2'd1,
        FN_KILL = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_SCAN,
        ST_SET_WRITE,
        ST_KILL_SCAN,
        ST_TICK_SCAN,
        ST_TICK_FLUSH
    } t_state;

    typedef struct packed {
        logic  load;
        logic  div_start;
        logic  scan;
        t_func op;
        logic  set_write;
        logic  flush;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic hit;
        logic fire_stop;
        logic pend_vld;
        logic out_free;
        logic engine;
    } t_sts;

endpackage

`default_nettype wire

>>> design/mtt_div.sv
// divider by the base tick using a reciprocal multiply; dividend and then quotient are registered
// depends on mtt_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtt_div #(
    parameter int BASE_TICK_MS = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [mtt_pkg::IV_W-1:0]  i_dividend,
    output logic      [mtt_pkg::IV_W-1:0]  o_quot,
    output logic                           o_done
);

    // floor(x / d) == (x * ceil(2^s / d)) >> s for s = width + ceil(log2 d)
    localparam int          SHIFT   = mtt_pkg::IV_W + $clog2(BASE_TICK_MS);
    localparam int          MUL_W   = mtt_pkg::IV_W + 1;
    localparam int          PROD_W  = mtt_pkg::IV_W + MUL_W;
    localparam logic [63:0] SCALE   = 64'd1 << SHIFT;
    localparam logic [63:0] RECIP64 = (SCALE + 64'(BASE_TICK_MS) - 64'd1) / 64'(BASE_TICK_MS);
    localparam logic [MUL_W-1:0] RECIP = RECIP64[MUL_W-1:0];

    logic                     r_busy;
    logic [mtt_pkg::IV_W-1:0] r_x;
    logic [mtt_pkg::IV_W-1:0] r_q;

    logic [PROD_W-1:0]        prod;
    logic [PROD_W-1:0]        prod_sh;

    always_comb begin
        prod    = {{MUL_W{1'b0}}, r_x} * {{mtt_pkg::IV_W{1'b0}}, RECIP};
        prod_sh = prod >> SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
        end
        if (r_busy) begin
            r_q <= prod_sh[mtt_pkg::IV_W-1:0];
        end
    end

    assign o_quot = r_q;
    assign o_done = !r_busy;

endmodule

`default_nettype wire

>>> design/mtt_dp.sv
// datapath: timer memory, enable flags, scan pipeline, fire and output registers
// depends on mtt_pkg and mtt_div
`timescale 1ns / 1ps
`default_nettype none

module mtt_dp #(
    parameter int TABLE_DEPTH  = 16,
    parameter int BASE_TICK_MS = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire mtt_pkg::t_cmd             i_cmd,
    output mtt_pkg::t_sts                  o_sts,
    input  wire logic [mtt_pkg::ID_W-1:0]  i_id,
    input  wire logic [mtt_pkg::IV_W-1:0]  i_interval,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_wdata,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output logic      [mtt_pkg::ID_W-1:0]  o_out_id,
    output logic                           o_out_last
);

    localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int QMAX  = ((1 << mtt_pkg::IV_W) - 1) / BASE_TICK_MS;
    localparam int PW    = $clog2(QMAX + 1);
    localparam int CW    = PW + 1;
    localparam int MW    = mtt_pkg::ID_W + PW + CW;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // entry word: id, period, count
    logic [MW-1:0]            r_mem [TABLE_DEPTH];
    logic [MW-1:0]            r_rdata;
    logic [TABLE_DEPTH-1:0]   r_en;
    logic [TABLE_DEPTH-1:0]   r_wrt;
    logic                     r_engine;
    logic                     r_repeat;

    logic [CNT_W-1:0]         r_rd_cnt;
    logic                     r_ev_vld;
    logic [IW-1:0]            r_ev_idx;
    logic [mtt_pkg::ID_W-1:0] r_id;
    logic                     r_match_found;
    logic [IW-1:0]            r_match_idx;
    logic                     r_free_found;
    logic [IW-1:0]            r_free_idx;

    logic                     r_pend_vld;
    logic [mtt_pkg::ID_W-1:0] r_pend_id;
    logic                     r_out_vld;
    logic [mtt_pkg::ID_W-1:0] r_out_id;
    logic                     r_out_last;

    logic [mtt_pkg::IV_W-1:0] quot;
    logic                     div_done;

    logic [mtt_pkg::ID_W-1:0] rd_id;
    logic [PW-1:0]            rd_per;
    logic [CW-1:0]            rd_cnt_f;
    logic [CW-1:0]            nxt_cnt;
    logic [mtt_pkg::ID_W-1:0] id_eff;
    logic                     ent_en;
    logic                     ev;
    logic                     id_hit;
    logic                     fire;
    logic                     out_free;
    logic                     stall;
    logic                     adv;
    logic                     ev_done;
    logic                     rd_en;
    logic [IW-1:0]            rd_addr;
    logic                     is_set;
    logic                     is_kill;
    logic                     is_tick;
    logic                     tick_wr;
    logic                     set_do;
    logic [IW-1:0]            tgt;
    logic                     mem_we;
    logic [IW-1:0]            mem_waddr;
    logic [MW-1:0]            mem_wdata;
    logic                     fire_done;
    logic                     push_out;
    logic                     flush_out;

    mtt_div #(
        .BASE_TICK_MS (BASE_TICK_MS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_interval),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    always_comb begin
        rd_id     = r_rdata[MW-1 -: mtt_pkg::ID_W];
        rd_per    = r_rdata[CW +: PW];
        rd_cnt_f  = r_rdata[CW-1:0];
        is_set    = (i_cmd.op == mtt_pkg::FN_SET);
        is_kill   = (i_cmd.op == mtt_pkg::FN_KILL);
        is_tick   = (i_cmd.op == mtt_pkg::FN_TICK);
        // never written entries read as id zero
        id_eff    = r_wrt[r_ev_idx] ? rd_id : '0;
        ent_en    = r_en[r_ev_idx];
        ev        = i_cmd.scan && r_ev_vld;
        id_hit    = ev && (id_eff == r_id);
        fire      = ev && is_tick && ent_en && ({1'b0, rd_per} < rd_cnt_f);
        out_free  = !r_out_vld || i_out_ready;
        // a second fire needs the output register to take the held one
        stall     = fire && r_pend_vld && !out_free;
        adv       = i_cmd.scan && !stall;
        ev_done   = ev && !stall;
        rd_en     = adv && (r_rd_cnt != DEPTH_CNT);
        rd_addr   = r_rd_cnt[IW-1:0];
        nxt_cnt   = fire ? {CW{1'b0}} : rd_cnt_f + CW'(1);
        tick_wr   = ev_done && is_tick && ent_en;
        set_do    = i_cmd.set_write && (r_match_found || r_free_found);
        tgt       = r_match_found ? r_match_idx : r_free_idx;
        mem_we    = tick_wr || set_do;
        mem_waddr = set_do ? tgt : r_ev_idx;
        mem_wdata = set_do ? {r_id, quot[PW-1:0], {CW{1'b0}}} : {rd_id, rd_per, nxt_cnt};
        fire_done = fire && ev_done;
        push_out  = fire_done && r_pend_vld;
        flush_out = i_cmd.flush && out_free && r_pend_vld;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt      <= '0;
            r_ev_vld      <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end else if (i_cmd.load) begin
            r_rd_cnt      <= '0;
            r_ev_vld      <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end else if (adv) begin
            r_ev_vld <= rd_en;
            if (rd_en) begin
                r_rd_cnt <= r_rd_cnt + CNT_W'(1);
            end
            if (ev_done && is_set) begin
                if (id_hit && !r_match_found) begin
                    r_match_found <= 1'b1;
                end
                if (!ent_en && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id <= i_id;
        end
        if (rd_en) begin
            r_ev_idx <= rd_addr;
        end
        if (ev_done && is_set && id_hit && !r_match_found) begin
            r_match_idx <= r_ev_idx;
        end
        if (ev_done && is_set && !ent_en && !r_free_found) begin
            r_free_idx <= r_ev_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= '0;
            r_wrt    <= '0;
            r_engine <= 1'b0;
            r_repeat <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_repeat <= i_cfg_wdata;
            end
            if (set_do) begin
                r_en[tgt]  <= 1'b1;
                r_wrt[tgt] <= 1'b1;
                r_engine   <= 1'b1;
            end
            if (id_hit && is_kill) begin
                r_en[r_ev_idx] <= 1'b0;
            end
            if (fire_done && !r_repeat) begin
                r_engine <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (fire_done) begin
                r_pend_vld <= 1'b1;
            end else if (flush_out) begin
                r_pend_vld <= 1'b0;
            end
            if (push_out || flush_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_done) begin
            r_pend_id <= rd_id;
        end
        if (push_out || flush_out) begin
            r_out_id   <= r_pend_id;
            r_out_last <= flush_out;
        end
    end

    always_comb begin
        o_sts.scan_done = (r_rd_cnt == DEPTH_CNT) && !r_ev_vld;
        o_sts.div_done  = div_done;
        o_sts.hit       = id_hit && is_kill;
        o_sts.fire_stop = fire_done && !r_repeat;
        o_sts.pend_vld  = r_pend_vld;
        o_sts.out_free  = out_free;
        o_sts.engine    = r_engine;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_id    = r_out_id;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

>>> design/mtt_ctrl.sv
// controller state machine: sequences set, kill and tick transactions
// depends on mtt_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtt_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [mtt_pkg::FUNC_W-1:0]  i_func,
    output logic                             o_in_ready,
    input  wire mtt_pkg::t_sts               i_sts,
    output mtt_pkg::t_cmd                    o_cmd
);

    mtt_pkg::t_state r_state;
    mtt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.op   = mtt_pkg::FN_TICK;
        o_in_ready = 1'b0;
        case (r_state)
            mtt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (mtt_pkg::t_func'(i_func))
                        mtt_pkg::FN_TICK: begin
                            if (i_sts.engine) begin
                                n_state = mtt_pkg::ST_TICK_SCAN;
                            end
                        end
                        mtt_pkg::FN_SET: begin
                            o_cmd.div_start = 1'b1;
                            n_state         = mtt_pkg::ST_SET_SCAN;
                        end
                        mtt_pkg::FN_KILL: begin
                            n_state = mtt_pkg::ST_KILL_SCAN;
                        end
                        default: begin
                            n_state = mtt_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mtt_pkg::ST_SET_SCAN: begin
                o_cmd.scan = 1'b1;
                o_cmd.op   = mtt_pkg::FN_SET;
                if (i_sts.scan_done && i_sts.div_done) begin
                    n_state = mtt_pkg::ST_SET_WRITE;
                end
            end
            mtt_pkg::ST_SET_WRITE: begin
                o_cmd.op        = mtt_pkg::FN_SET;
                o_cmd.set_write = 1'b1;
                n_state         = mtt_pkg::ST_IDLE;
            end
            mtt_pkg::ST_KILL_SCAN: begin
                o_cmd.scan = 1'b1;
                o_cmd.op   = mtt_pkg::FN_KILL;
                if (i_sts.hit || i_sts.scan_done) begin
                    n_state = mtt_pkg::ST_IDLE;
                end
            end
            mtt_pkg::ST_TICK_SCAN: begin
                o_cmd.scan = 1'b1;
                o_cmd.op   = mtt_pkg::FN_TICK;
                if (i_sts.fire_stop) begin
                    n_state = mtt_pkg::ST_TICK_FLUSH;
                end else if (i_sts.scan_done) begin
                    n_state = i_sts.pend_vld ? mtt_pkg::ST_TICK_FLUSH : mtt_pkg::ST_IDLE;
                end
            end
            mtt_pkg::ST_TICK_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (i_sts.out_free) begin
                    n_state = mtt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mtt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/multi_timer_table.sv
// top level of the multi timer table: controller plus datapath
// depends on mtt_pkg, mtt_ctrl, mtt_dp (and mtt_div below it)
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser func, tdata timer_id, interval_ms
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata fired_id, tlast last_fired
// cfg       in         i_cfg_we                       i_cfg_wdata repeat_mode
//
// every transaction is accepted in the idle state, then
// set: a scan of every entry, then a write once the quotient is ready
// kill: a scan, one memory read per entry, ending at the first id hit
// tick: if the engine is on, a scan (ends at a fire without repeat), a flush of a held fire
// a tick holds while a fire meets a full output register
// reset (synchronous) clears all flags but sets repeat mode; entry words need no clearing
`timescale 1ns / 1ps
`default_nettype none

module multi_timer_table #(
    parameter int TABLE_DEPTH  = 16,
    parameter int BASE_TICK_MS = 10
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [15:0] timer_id, [39:16] interval_ms
    input  wire logic [mtt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] func
    input  wire logic [mtt_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [15:0] fired_id
    output logic      [mtt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                                  m_axis_tlast,
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_wdata
);

    mtt_pkg::t_cmd cmd;
    mtt_pkg::t_sts sts;

    mtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mtt_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .BASE_TICK_MS (BASE_TICK_MS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_id        (s_axis_tdata[mtt_pkg::ID_W-1:0]),
        .i_interval  (s_axis_tdata[mtt_pkg::ID_W +: mtt_pkg::IV_W]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_id    (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> design/mtt_chk.sv
// port-level checker for the multi timer table, bound to the top level
// depends on mtt_pkg and multi_timer_table_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "multi_timer_table_macros.svh"

module mtt_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [mtt_pkg::FUNC_W-1:0]     s_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [mtt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                           m_axis_tlast
);

    logic                            set_kill_acc;
    logic                            out_stall;
    logic [mtt_pkg::OUT_DATA_W:0]    out_word;

    assign set_kill_acc = s_axis_tvalid && s_axis_tready
                          && (s_axis_tuser == mtt_pkg::FN_SET || s_axis_tuser == mtt_pkg::FN_KILL);
    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_word     = {m_axis_tlast, m_axis_tdata};

    `MTT_ASSERT_RST(a_rst_no_out, !m_axis_tvalid, "result valid right after reset")
    `MTT_ASSERT_RST(a_rst_ready, s_axis_tready, "input not ready right after reset")
    `MTT_ASSERT_NEXT(a_set_kill_busy, set_kill_acc, !s_axis_tready, "set or kill left input ready")
    `MTT_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "result changed")

endmodule

bind multi_timer_table mtt_chk u_mtt_chk (.*);

`default_nettype wire

>>> test/tb_multi_timer_table.sv
// self-checking testbench for multi_timer_table: directed table then random set/kill/tick traffic
// depends on mtt_pkg and the multi_timer_table rtl; expected fires come from a local timer model
`timescale 1ns / 1ps

module tb_multi_timer_table;

    localparam int CLK_PERIOD   = 8;
    localparam int TABLE_DEPTH  = 16;
    localparam int BASE_TICK    = 10;
    localparam int IDLE_CYCLES  = 48;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int ITEM_TARGET  = 270;
    localparam int POOL_SIZE    = 20;
    localparam int N_DIRECTED   = 26;

    localparam logic [mtt_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_SINGLE} t_exp_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [mtt_pkg::FUNC_W-1:0]  func;
        logic [mtt_pkg::ID_W-1:0]    id;
        logic [mtt_pkg::IV_W-1:0]    iv;      // bit 0 carries the mode on cfg rows
        t_exp_kind                   exp_kind;
        logic [mtt_pkg::ID_W-1:0]    fire_id;
    } t_stim_row;

    typedef struct packed {
        logic [mtt_pkg::ID_W-1:0] id;
        logic                     last_flag;
    } t_fire;

    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_KILL, 16'h1234, 24'h000000, EXP_NONE,    16'h0000},
        '{ROW_ITEM, FN_UNUSED,        16'hFFFF, 24'hFFFFFF, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_SET,  16'hFFFF, 24'h000000, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_SINGLE,  16'hFFFF},
        '{ROW_ITEM, mtt_pkg::FN_SET,  16'h0000, 24'h000009, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_PREDICT, 16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_SET,  16'h00AB, 24'hFFFFFF, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_KILL, 16'hFFFF, 24'h000000, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_SET,  16'h5555, 24'h000019, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_PREDICT, 16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_PREDICT, 16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_PREDICT, 16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_PREDICT, 16'h0000},
        '{ROW_CFG,  mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_PREDICT, 16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_PREDICT, 16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_NONE,    16'h0000},
        '{ROW_CFG,  mtt_pkg::FN_TICK, 16'h0000, 24'h000001, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_SET,  16'h5555, 24'h000064, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_PREDICT, 16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_KILL, 16'h0000, 24'h000000, EXP_NONE,    16'h0000},
        '{ROW_ITEM, mtt_pkg::FN_TICK, 16'h0000, 24'h000000, EXP_PREDICT, 16'h0000}
    };

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // [15:0] timer_id, [39:16] interval_ms
    logic [mtt_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [mtt_pkg::FUNC_W-1:0]     s_axis_tuser  = '0;   // [1:0] func
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [mtt_pkg::OUT_DATA_W-1:0] m_axis_tdata;         // [15:0] fired_id
    logic                           m_axis_tlast;
    logic                           i_cfg_we      = 1'b0;
    logic                           i_cfg_wdata   = 1'b0;

    // timer table model
    logic [mtt_pkg::ID_W-1:0] slot_tag   [TABLE_DEPTH];
    logic [20:0]              slot_per   [TABLE_DEPTH];
    logic [21:0]              slot_cnt   [TABLE_DEPTH];
    bit                       slot_on    [TABLE_DEPTH];
    bit                       engine_on;
    bit                       repeat_on;

    t_fire                    tick_fires     [$];
    t_fire                    expected_fires [$];
    logic [mtt_pkg::ID_W-1:0] id_pool [POOL_SIZE];

    int items_sent     = 0;
    int fires_checked  = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int stall_left     = 0;
    int phase          = 0;
    bit no_idle        = 1'b0;

    multi_timer_table #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .BASE_TICK_MS (BASE_TICK)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic reset_timers();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_tag[i] = '0;
            slot_per[i] = '0;
            slot_cnt[i] = '0;
            slot_on[i]  = 1'b0;
        end
        engine_on = 1'b0;
        repeat_on = 1'b1;
    endtask

    // applies one operation to the table model, fires land in tick_fires
    task automatic advance_timers(input logic [mtt_pkg::FUNC_W-1:0] func,
                                  input logic [mtt_pkg::ID_W-1:0] id,
                                  input logic [mtt_pkg::IV_W-1:0] iv);
        int          hit;
        logic [21:0] prior;
        hit = -1;
        tick_fires.delete();
        case (func)
            mtt_pkg::FN_SET: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (hit < 0 && slot_tag[i] == id) hit = i;
                end
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (hit < 0 && !slot_on[i]) hit = i;
                end
                if (hit >= 0) begin
                    slot_tag[hit] = id;
                    slot_per[hit] = 21'(iv / BASE_TICK);
                    slot_cnt[hit] = '0;
                    slot_on[hit]  = 1'b1;
                    engine_on     = 1'b1;
                end
            end
            mtt_pkg::FN_KILL: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (hit < 0 && slot_tag[i] == id) hit = i;
                end
                if (hit >= 0) slot_on[hit] = 1'b0;
            end
            mtt_pkg::FN_TICK: begin
                if (engine_on) begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (slot_on[i]) begin
                            prior       = slot_cnt[i];
                            slot_cnt[i] = prior + 22'd1;
                            if ({1'b0, slot_per[i]} < prior) begin
                                slot_cnt[i] = '0;
                                tick_fires.push_back('{id: slot_tag[i], last_flag: 1'b0});
                                if (!repeat_on) begin
                                    engine_on = 1'b0;
                                    break;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (tick_fires.size() > 0) tick_fires[tick_fires.size() - 1].last_flag = 1'b1;
    endtask

    task automatic send_item(input logic [mtt_pkg::FUNC_W-1:0] func,
                             input logic [mtt_pkg::ID_W-1:0] id,
                             input logic [mtt_pkg::IV_W-1:0] iv, input t_exp_kind exp_kind,
                             input logic [mtt_pkg::ID_W-1:0] fire_id);
        int gap;
        gap = (no_idle || $urandom_range(0, 99) < 50) ? 0 : gap_length();
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {iv, id};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        advance_timers(func, id, iv);
        case (exp_kind)
            EXP_PREDICT: foreach (tick_fires[i]) expected_fires.push_back(tick_fires[i]);
            EXP_SINGLE:  expected_fires.push_back('{id: fire_id, last_flag: 1'b1});
            default: ;
        endcase
    endtask

    // drain outstanding fires, then let a silent scan or a set finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_fires.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit mode);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        repeat_on = mode;
    endtask

    // output monitor, downstream stalls and watchdog
    always @(posedge i_clk) begin
        t_fire got;
        cycle_count++;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            fires_checked++;
            if (expected_fires.size() == 0) begin
                report_mismatch($sformatf("fire of id %h with none pending", m_axis_tdata));
            end else begin
                got = expected_fires.pop_front();
                if (m_axis_tdata !== got.id) begin
                    report_mismatch($sformatf("fired_id %h, want %h", m_axis_tdata, got.id));
                end
                if (m_axis_tlast !== got.last_flag) begin
                    report_mismatch($sformatf("last_fired %b, want %b for id %h",
                                              m_axis_tlast, got.last_flag, got.id));
                end
            end
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 25) stall_left = gap_length();
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_stim_row                   row;
        int                          run_len;
        int                          pick;
        int                          r;
        logic [mtt_pkg::FUNC_W-1:0]  func;
        logic [mtt_pkg::ID_W-1:0]    id;
        logic [mtt_pkg::IV_W-1:0]    iv;

        for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = mtt_pkg::ID_W'($urandom);
        reset_timers();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED[k];
            if (row.kind == ROW_CFG) begin
                write_mode(row.iv[0]);
            end else begin
                send_item(row.func, row.id, row.iv, row.exp_kind, row.fire_id);
            end
        end

        while (items_sent < ITEM_TARGET && phase < 60) begin
            write_mode(phase % 3 != 0);
            no_idle = ($urandom_range(0, 4) == 0);
            run_len = $urandom_range(25, 45);
            if (run_len > ITEM_TARGET - items_sent) run_len = ITEM_TARGET - items_sent;
            repeat (run_len) begin
                pick = $urandom_range(0, 99);
                r    = $urandom_range(0, 99);
                id   = ($urandom_range(0, 9) == 0) ? mtt_pkg::ID_W'($urandom)
                                                   : id_pool[$urandom_range(0, POOL_SIZE - 1)];
                if (r < 80) begin
                    iv = mtt_pkg::IV_W'($urandom_range(0, 49));
                end else if (r < 95) begin
                    iv = mtt_pkg::IV_W'($urandom_range(0, 400));
                end else begin
                    iv = mtt_pkg::IV_W'($urandom);
                end
                if (pick < 4) begin
                    func = FN_UNUSED;
                end else if (pick < 8) begin
                    func = mtt_pkg::FN_KILL;
                    id   = mtt_pkg::ID_W'($urandom);
                end else if (pick < 36) begin
                    func = mtt_pkg::FN_SET;
                end else if (pick < 46) begin
                    func = mtt_pkg::FN_KILL;
                end else begin
                    func = mtt_pkg::FN_TICK;
                end
                send_item(func, id, iv, EXP_PREDICT, '0);
            end
            phase++;
        end

        no_idle = 1'b0;
        settle();
        if (expected_fires.size() != 0) begin
            report_mismatch($sformatf("%0d fires never arrived", expected_fires.size()));
        end
        $display("%0d table transactions: %0d directed rows, %0d random phases in both modes",
                 items_sent, N_DIRECTED, phase);
        $display("%0d timer fires compared, %0d mismatches", fires_checked, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/mtt_pkg.sv
design/mtt_div.sv
design/mtt_dp.sv
design/mtt_ctrl.sv
design/multi_timer_table.sv
design/mtt_chk.sv
test/tb_multi_timer_table.sv
